/* sv/cis_count_selector_macros.svh */
// Assertion helpers for the CIS count selector.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef CIS_COUNT_SELECTOR_MACROS_SVH
`define CIS_COUNT_SELECTOR_MACROS_SVH

// Same-cycle implication.
`define CIS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cis_count_selector: same-cycle check failed");

// Next-cycle implication.
`define CIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cis_count_selector: next-cycle check failed");

`endif

/* sv/cis_pkg.sv */
`default_nettype none

package cis_pkg;

    localparam int unsigned CNT_W   = 8;
    localparam int unsigned STRAT_W = 2;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DATA_W  = 8;

    // Register indexes on the write port
    localparam logic [IDX_W-1:0] CFG_EXPECTED_DEVICES = 3'd0;
    localparam logic [IDX_W-1:0] CFG_STRATEGY_SELECT  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_AVAIL_SINK       = 3'd2;
    localparam logic [IDX_W-1:0] CFG_AVAIL_SOURCE     = 3'd3;

    // Direction codes
    localparam logic DIR_SINK   = 1'b0;
    localparam logic DIR_SOURCE = 1'b1;

    typedef struct packed {
        logic               new_search;
        logic               direction;
        logic [STRAT_W-1:0] entry_strategy;
        logic [CNT_W-1:0]   endpoint_count;
        logic [CNT_W-1:0]   device_count;
        logic               last_entry;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] bidir_streams;
        logic [CNT_W-1:0] sink_only_streams;
        logic [CNT_W-1:0] source_only_streams;
        logic             config_fits;
    } result_t;

    // Pipeline control between the top level and the stages
    typedef struct packed {
        logic advance;   // entry in the input register moves on this cycle
        logic emit;      // that entry produces a result
    } stage_ctl_t;

endpackage

`default_nettype wire

/* sv/cis_in_stage.sv */
`default_nettype none

// Input register: holds one entry until the evaluation logic takes it.
module cis_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire logic           advance,
    input  wire cis_pkg::entry_t entry_in,
    output logic                valid,
    output cis_pkg::entry_t     entry
);

    logic            valid_reg;
    logic            valid_next;
    cis_pkg::entry_t entry_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_in;
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

/* sv/cis_eval.sv */
`default_nettype none

// Configuration registers, per-configuration accumulators, stream counts,
// and the end-of-configuration checks.
module cis_eval (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [cis_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [cis_pkg::DATA_W-1:0] cfg_data,
    input  wire cis_pkg::stage_ctl_t        ctl,
    input  wire cis_pkg::entry_t            entry,
    output cis_pkg::result_t                result
);

    localparam int unsigned CW = cis_pkg::CNT_W;
    localparam int unsigned SW = cis_pkg::STRAT_W;

    logic [CW-1:0] expected_devices_reg;
    logic [SW-1:0] strategy_select_reg;
    logic [CW-1:0] avail_sink_reg;
    logic [CW-1:0] avail_source_reg;

    logic [CW-1:0] sink_sum_reg,          sink_sum_next;
    logic [CW-1:0] source_sum_reg,        source_sum_next;
    logic [CW-1:0] max_devices_reg,       max_devices_next;
    logic          strategy_reject_reg,   strategy_reject_next;
    logic [CW-1:0] bidir_count_reg,       bidir_count_next;
    logic [CW-1:0] sink_only_count_reg,   sink_only_count_next;
    logic [CW-1:0] source_only_count_reg, source_only_count_next;

    logic [CW-1:0] acc_sink;
    logic [CW-1:0] acc_source;
    logic [CW-1:0] acc_max;
    logic          acc_reject;
    logic [CW-1:0] cur_bidir;
    logic [CW-1:0] cur_sink_only;
    logic [CW-1:0] cur_source_only;
    logic [CW-1:0] pair_cnt;
    logic [CW-1:0] rem_sink;
    logic [CW-1:0] rem_source;
    logic          fits;
    logic [CW-1:0] upd_bidir;
    logic [CW-1:0] upd_sink_only;
    logic [CW-1:0] upd_source_only;

    // Config writes; out-of-range index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_devices_reg <= CW'(1);
            strategy_select_reg  <= '0;
            avail_sink_reg       <= '0;
            avail_source_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cis_pkg::CFG_EXPECTED_DEVICES: expected_devices_reg <= cfg_data[CW-1:0];
                cis_pkg::CFG_STRATEGY_SELECT:  strategy_select_reg  <= cfg_data[SW-1:0];
                cis_pkg::CFG_AVAIL_SINK:       avail_sink_reg       <= cfg_data[CW-1:0];
                cis_pkg::CFG_AVAIL_SOURCE:     avail_source_reg     <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Accumulate this entry (sums wrap at 8 bits)
    always_comb
    begin
        acc_sink   = sink_sum_reg;
        acc_source = source_sum_reg;
        acc_reject = strategy_reject_reg;
        if (entry.direction == cis_pkg::DIR_SINK)
        begin
            acc_sink   = sink_sum_reg + entry.endpoint_count;
            acc_reject = strategy_reject_reg |
                         (entry.entry_strategy != strategy_select_reg);
        end
        else
        begin
            acc_source = source_sum_reg + entry.endpoint_count;
        end
        acc_max = (entry.device_count > max_devices_reg) ? entry.device_count
                                                         : max_devices_reg;
    end

    // Stream counts after an optional new-search clear
    assign cur_bidir       = entry.new_search ? '0 : bidir_count_reg;
    assign cur_sink_only   = entry.new_search ? '0 : sink_only_count_reg;
    assign cur_source_only = entry.new_search ? '0 : source_only_count_reg;

    // Rejection checks
    always_comb
    begin
        fits = 1'b1;
        if (acc_reject)
            fits = 1'b0;
        if (acc_max != expected_devices_reg)
            fits = 1'b0;
        if ((avail_sink_reg == '0) && (acc_sink != '0))
            fits = 1'b0;
        if ((avail_source_reg == '0) && (acc_source != '0))
            fits = 1'b0;
        if ((expected_devices_reg == CW'(1)) &&
            ((acc_sink > avail_sink_reg) || (acc_source > avail_source_reg)))
            fits = 1'b0;
        if ((acc_sink == '0) && ((cur_sink_only != '0) || (cur_bidir != '0)))
            fits = 1'b0;
        if ((acc_source == '0) && ((cur_source_only != '0) || (cur_bidir != '0)))
            fits = 1'b0;
    end

    // Count update, bidirectional preferred
    assign pair_cnt   = (acc_sink < acc_source) ? acc_sink : acc_source;
    assign rem_sink   = acc_sink - pair_cnt;
    assign rem_source = acc_source - pair_cnt;

    always_comb
    begin
        upd_bidir       = cur_bidir;
        upd_sink_only   = cur_sink_only;
        upd_source_only = cur_source_only;
        priority if (pair_cnt > cur_bidir)
        begin
            upd_bidir       = pair_cnt;
            upd_sink_only   = rem_sink;
            upd_source_only = rem_source;
        end
        else if ((cur_bidir == '0) && (cur_sink_only == '0) && (cur_source_only == '0))
        begin
            upd_sink_only   = rem_sink;
            upd_source_only = rem_source;
        end
        else
        begin
            upd_bidir = cur_bidir;
        end
    end

    always_comb
    begin
        sink_sum_next          = sink_sum_reg;
        source_sum_next        = source_sum_reg;
        max_devices_next       = max_devices_reg;
        strategy_reject_next   = strategy_reject_reg;
        bidir_count_next       = bidir_count_reg;
        sink_only_count_next   = sink_only_count_reg;
        source_only_count_next = source_only_count_reg;
        if (ctl.advance)
        begin
            bidir_count_next       = cur_bidir;
            sink_only_count_next   = cur_sink_only;
            source_only_count_next = cur_source_only;
            if (ctl.emit)
            begin
                sink_sum_next        = '0;
                source_sum_next      = '0;
                max_devices_next     = '0;
                strategy_reject_next = 1'b0;
                if (fits)
                begin
                    bidir_count_next       = upd_bidir;
                    sink_only_count_next   = upd_sink_only;
                    source_only_count_next = upd_source_only;
                end
            end
            else
            begin
                sink_sum_next        = acc_sink;
                source_sum_next      = acc_source;
                max_devices_next     = acc_max;
                strategy_reject_next = acc_reject;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_sum_reg          <= '0;
            source_sum_reg        <= '0;
            max_devices_reg       <= '0;
            strategy_reject_reg   <= 1'b0;
            bidir_count_reg       <= '0;
            sink_only_count_reg   <= '0;
            source_only_count_reg <= '0;
        end
        else
        begin
            sink_sum_reg          <= sink_sum_next;
            source_sum_reg        <= source_sum_next;
            max_devices_reg       <= max_devices_next;
            strategy_reject_reg   <= strategy_reject_next;
            bidir_count_reg       <= bidir_count_next;
            sink_only_count_reg   <= sink_only_count_next;
            source_only_count_reg <= source_only_count_next;
        end
    end

    assign result.bidir_streams       = fits ? upd_bidir       : cur_bidir;
    assign result.sink_only_streams   = fits ? upd_sink_only   : cur_sink_only;
    assign result.source_only_streams = fits ? upd_source_only : cur_source_only;
    assign result.config_fits         = fits;

endmodule

`default_nettype wire

/* sv/cis_out_stage.sv */
`default_nettype none

// Result register: holds one request until the consumer takes it.
module cis_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire cis_pkg::result_t result_in,
    input  wire logic             stall,
    output logic                  valid,
    output cis_pkg::result_t      result
);

    logic             valid_reg;
    logic             valid_next;
    cis_pkg::result_t result_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* sv/cis_count_selector.sv */
// Path: a last-entry request is taken into the input register; its result
//   is loaded into the result register once that is free, raising out_valid.
// Throughput: one entry request per cycle; a last entry waits only while the
//   result register is full and stalled by the consumer.
// Reset (rst_n, async, active low): accumulators and stream counts clear,
//   expected_devices = 1, other config registers 0, no request pending.
`default_nettype none

`include "cis_count_selector_macros.svh"

module cis_count_selector (
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // Config write port
    input  wire logic                       cfg_we,
    input  wire logic [cis_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [cis_pkg::DATA_W-1:0] cfg_data,

    // Entry requests
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       new_search,
    input  wire logic                       direction,
    input  wire logic [cis_pkg::STRAT_W-1:0] entry_strategy,
    input  wire logic [cis_pkg::CNT_W-1:0]  endpoint_count,
    input  wire logic [cis_pkg::CNT_W-1:0]  device_count,
    input  wire logic                       last_entry,

    // Result requests
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [cis_pkg::CNT_W-1:0]       bidir_streams,
    output logic [cis_pkg::CNT_W-1:0]       sink_only_streams,
    output logic [cis_pkg::CNT_W-1:0]       source_only_streams,
    output logic                            config_fits
);

    cis_pkg::entry_t     entry_in;
    cis_pkg::entry_t     s1_entry;
    logic                s1_valid;
    logic                in_load;
    logic                out_free;
    cis_pkg::stage_ctl_t ctl;
    cis_pkg::result_t    eval_result;
    cis_pkg::result_t    out_result;

    assign entry_in.new_search     = new_search;
    assign entry_in.direction      = direction;
    assign entry_in.entry_strategy = entry_strategy;
    assign entry_in.endpoint_count = endpoint_count;
    assign entry_in.device_count   = device_count;
    assign entry_in.last_entry     = last_entry;

    // The result register frees up this cycle if empty or being drained.
    assign out_free = !out_valid || !out_stall;

    // Non-last entries never wait; a last entry needs room for its result.
    assign ctl.advance = s1_valid && (!s1_entry.last_entry || out_free);
    assign ctl.emit    = s1_valid && s1_entry.last_entry;

    // The input register takes a new request whenever it is empty or its entry moves on.
    assign in_stall = s1_valid && !ctl.advance;
    assign in_load  = in_valid && !in_stall;

    cis_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_load),
        .advance  (ctl.advance),
        .entry_in (entry_in),
        .valid    (s1_valid),
        .entry    (s1_entry)
    );

    // Accumulate, check and update stream counts in one pass
    cis_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .entry     (s1_entry),
        .result    (eval_result)
    );

    cis_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctl.advance && ctl.emit),
        .result_in (eval_result),
        .stall     (out_stall),
        .valid     (out_valid),
        .result    (out_result)
    );

    assign bidir_streams       = out_result.bidir_streams;
    assign sink_only_streams   = out_result.sink_only_streams;
    assign source_only_streams = out_result.source_only_streams;
    assign config_fits         = out_result.config_fits;

    // Only a held last entry can push back on the producer.
    `CIS_ASSERT_NOW(a_stall_needs_entry, in_stall, s1_valid && s1_entry.last_entry)
    // A last entry that moves on always shows up as a result next cycle.
    `CIS_ASSERT_NEXT(a_emit_shows, ctl.advance && ctl.emit, out_valid)
    // A new result never lands on one that is still stalled.
    `CIS_ASSERT_NOW(a_no_overwrite, ctl.advance && ctl.emit, out_free)

endmodule

`default_nettype wire

/* sim/tb_cis_count_selector.sv */
module tb_cis_count_selector;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    // Margin after the last owed result so that the pipeline empties.
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_REQUESTS = 175;
    localparam int MAX_REPORTS    = 10;
    // Worst case per request is a sender gap plus a result stall, over about
    // 1250 requests; the timeout leaves a wide margin.
    localparam int TIMEOUT_CYCLES = 400000;

    localparam int unsigned CW = cis_pkg::CNT_W;
    localparam int unsigned SW = cis_pkg::STRAT_W;
    localparam int unsigned IW = cis_pkg::IDX_W;
    localparam int unsigned DW = cis_pkg::DATA_W;

    // Models the block: per-configuration sums, the running stream counts
    // and the rejection checks, plus the queue of results still owed.
    class stream_count_board;
        logic [CW-1:0]   expected_devices;
        logic [SW-1:0]   strategy_select;
        logic [CW-1:0]   avail_sink;
        logic [CW-1:0]   avail_source;

        logic [CW-1:0]   sink_sum;
        logic [CW-1:0]   source_sum;
        logic [CW-1:0]   max_devices;
        bit              strategy_reject;
        logic [CW-1:0]   bidir;
        logic [CW-1:0]   sink_only;
        logic [CW-1:0]   source_only;

        cis_pkg::result_t pending_counts[$];
        int mismatches;
        int entries_seen;
        int results_seen;
        int configs_fit;

        function new();
            expected_devices = 8'd1;
            strategy_select  = '0;
            avail_sink       = '0;
            avail_source     = '0;
            sink_sum         = '0;
            source_sum       = '0;
            max_devices      = '0;
            strategy_reject  = 1'b0;
            bidir            = '0;
            sink_only        = '0;
            source_only      = '0;
            mismatches       = 0;
            entries_seen     = 0;
            results_seen     = 0;
            configs_fit      = 0;
        endfunction

        function void write_reg(logic [IW-1:0] index, logic [DW-1:0] data);
            case (index)
                cis_pkg::CFG_EXPECTED_DEVICES: expected_devices = data[CW-1:0];
                cis_pkg::CFG_STRATEGY_SELECT:  strategy_select  = data[SW-1:0];
                cis_pkg::CFG_AVAIL_SINK:       avail_sink       = data[CW-1:0];
                cis_pkg::CFG_AVAIL_SOURCE:     avail_source     = data[CW-1:0];
                default: ;
            endcase
        endfunction

        function void note_entry(cis_pkg::entry_t e);
            bit               fits;
            cis_pkg::result_t r;
            logic [CW-1:0]    b;
            entries_seen++;
            if (e.new_search)
            begin
                bidir       = '0;
                sink_only   = '0;
                source_only = '0;
            end
            if (e.direction == cis_pkg::DIR_SINK)
            begin
                if (e.entry_strategy != strategy_select)
                    strategy_reject = 1'b1;
                sink_sum = sink_sum + e.endpoint_count;
            end
            else
            begin
                source_sum = source_sum + e.endpoint_count;
            end
            if (e.device_count > max_devices)
                max_devices = e.device_count;
            if (!e.last_entry)
                return;

            fits = !(strategy_reject
                || max_devices != expected_devices
                || (avail_sink == 0 && sink_sum != 0)
                || (avail_source == 0 && source_sum != 0)
                || (expected_devices == 1
                    && (sink_sum > avail_sink || source_sum > avail_source))
                || (sink_sum == 0 && (sink_only != 0 || bidir != 0))
                || (source_sum == 0 && (source_only != 0 || bidir != 0)));
            if (fits)
            begin
                configs_fit++;
                b = (sink_sum < source_sum) ? sink_sum : source_sum;
                if (b > bidir)
                begin
                    bidir       = b;
                    sink_only   = sink_sum - b;
                    source_only = source_sum - b;
                end
                else if (bidir == 0 && sink_only == 0 && source_only == 0)
                begin
                    sink_only   = sink_sum - b;
                    source_only = source_sum - b;
                end
            end
            r.bidir_streams       = bidir;
            r.sink_only_streams   = sink_only;
            r.source_only_streams = source_only;
            r.config_fits         = fits;
            pending_counts.insert(pending_counts.size(), r);

            sink_sum        = '0;
            source_sum      = '0;
            max_devices     = '0;
            strategy_reject = 1'b0;
        endfunction

        function void check_result(cis_pkg::result_t got);
            cis_pkg::result_t want;
            results_seen++;
            if (pending_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result: bidir %0d sink %0d source %0d fits %0d",
                             got.bidir_streams, got.sink_only_streams,
                             got.source_only_streams, got.config_fits);
                return;
            end
            want = pending_counts.pop_front();
            if (got.bidir_streams !== want.bidir_streams
                || got.sink_only_streams !== want.sink_only_streams
                || got.source_only_streams !== want.source_only_streams
                || got.config_fits !== want.config_fits)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Mismatch: expected bidir %0d sink %0d source %0d fits %0d, got bidir %0d sink %0d source %0d fits %0d",
                             want.bidir_streams, want.sink_only_streams,
                             want.source_only_streams, want.config_fits,
                             got.bidir_streams, got.sink_only_streams,
                             got.source_only_streams, got.config_fits);
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_we    = 1'b0;
    logic [IW-1:0]     cfg_index = '0;
    logic [DW-1:0]     cfg_data  = '0;

    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic              new_search     = 1'b0;
    logic              direction      = 1'b0;
    logic [SW-1:0]     entry_strategy = '0;
    logic [CW-1:0]     endpoint_count = '0;
    logic [CW-1:0]     device_count   = '0;
    logic              last_entry     = 1'b0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CW-1:0]     bidir_streams;
    logic [CW-1:0]     sink_only_streams;
    logic [CW-1:0]     source_only_streams;
    logic              config_fits;

    stream_count_board board = new();

    // Set for the final phase: neither side idles there.
    bit quiet_tail = 1'b0;
    int requests_sent = 0;
    int settings_used = 0;
    int failures;

    cis_count_selector dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    // Observe both handshakes and the config port at every edge. All TB
    // drives are nonblocking, so these are the values before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                board.note_entry({new_search, direction, entry_strategy,
                                  endpoint_count, device_count, last_entry});
            if (out_valid && !out_stall)
                board.check_result({bidir_streams, sink_only_streams,
                                    source_only_streams, config_fits});
        end
    end

    // Consumer backpressure: random stall bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && rst_n && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Present one request and hold it until the block takes it. Called
    // right after a rising edge; returns right after the accepting edge.
    task automatic send_entry(input cis_pkg::entry_t e);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        new_search     <= e.new_search;
        direction      <= e.direction;
        entry_strategy <= e.entry_strategy;
        endpoint_count <= e.endpoint_count;
        device_count   <= e.device_count;
        last_entry     <= e.last_entry;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_fields(input int ns, input logic dir, input int strat,
                               input int endpoints, input int devices,
                               input int last);
        cis_pkg::entry_t e;
        e.new_search     = 1'(ns);
        e.direction      = dir;
        e.entry_strategy = SW'(strat);
        e.endpoint_count = CW'(endpoints);
        e.device_count   = CW'(devices);
        e.last_entry     = 1'(last);
        send_entry(e);
    endtask

    // Stop sending and wait for every owed result, then for the pipeline
    // to empty of entries that produce no result. The first edge lets the
    // monitor note the last accepted request.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] index,
                             input logic [DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes all four registers, plus one write to an unused index that
    // the block must ignore. Only called with the block idle.
    task automatic apply_settings(input logic [DW-1:0] devices,
                                  input logic [DW-1:0] strat_data,
                                  input logic [DW-1:0] sink,
                                  input logic [DW-1:0] source);
        logic [IW-1:0] spare;
        spare = IW'($urandom_range(int'(cis_pkg::CFG_AVAIL_SOURCE) + 1, (1 << IW) - 1));
        write_reg(cis_pkg::CFG_EXPECTED_DEVICES, devices);
        write_reg(cis_pkg::CFG_STRATEGY_SELECT, strat_data);
        write_reg(cis_pkg::CFG_AVAIL_SINK, sink);
        write_reg(spare, DW'($urandom));
        write_reg(cis_pkg::CFG_AVAIL_SOURCE, source);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // A well-formed configuration: 1..4 entries, sink strategy mostly the
    // required one, an entry usually carrying the expected device count, small
    // endpoint counts so that checks against the available counts can pass.
    task automatic send_set();
        cis_pkg::entry_t e;
        int n;
        int hot;
        n   = $urandom_range(1, 4);
        hot = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            e.new_search = (i == 0) && ($urandom_range(0, 6) == 0);
            e.direction  = 1'($urandom_range(0, 1));
            if (e.direction == cis_pkg::DIR_SOURCE || $urandom_range(0, 11) == 0)
                e.entry_strategy = SW'($urandom_range(0, 3));
            else
                e.entry_strategy = board.strategy_select;
            if ($urandom_range(0, 15) == 0)
                e.endpoint_count = CW'($urandom_range(0, 255));
            else
                e.endpoint_count = CW'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
                e.device_count = CW'($urandom_range(0, 255));
            else if (i == hot)
                e.device_count = board.expected_devices;
            else
                e.device_count = CW'($urandom_range(0, int'(board.expected_devices)));
            e.last_entry = (i == n - 1);
            send_entry(e);
        end
    endtask

    task automatic send_noise();
        cis_pkg::entry_t e;
        e.new_search     = 1'($urandom_range(0, 1));
        e.direction      = 1'($urandom_range(0, 1));
        e.entry_strategy = SW'($urandom_range(0, 3));
        e.endpoint_count = CW'($urandom_range(0, 255));
        e.device_count   = CW'($urandom_range(0, 255));
        e.last_entry     = 1'($urandom_range(0, 1));
        send_entry(e);
    endtask

    task automatic run_phase(input int count);
        int stop;
        stop = requests_sent + count;
        while (requests_sent < stop)
        begin
            if ($urandom_range(0, 4) != 0)
                send_set();
            else
                send_noise();
        end
        drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no endpoints available at all.
        send_fields(1, cis_pkg::DIR_SINK, 0, 1, 1, 1);     // sink endpoints, none available
        send_fields(0, cis_pkg::DIR_SOURCE, 0, 1, 1, 1);   // source endpoints, none available
        send_fields(0, cis_pkg::DIR_SINK, 0, 0, 1, 0);     // empty configuration fits
        send_fields(0, cis_pkg::DIR_SOURCE, 2, 0, 1, 1);
        drain();

        // Single device, sink strategy 1, three sink and two source endpoints.
        apply_settings(8'd1, 8'd1, 8'd3, 8'd2);
        send_fields(1, cis_pkg::DIR_SINK, 1, 2, 1, 0);     // source strategy is not checked
        send_fields(0, cis_pkg::DIR_SOURCE, 3, 2, 1, 1);
        send_fields(0, cis_pkg::DIR_SINK, 2, 1, 1, 1);     // sink strategy mismatch
        send_fields(0, cis_pkg::DIR_SINK, 1, 1, 2, 1);     // device count mismatch
        send_fields(0, cis_pkg::DIR_SINK, 1, 4, 1, 0);     // single-device sink shortfall
        send_fields(0, cis_pkg::DIR_SOURCE, 0, 1, 1, 1);
        send_fields(0, cis_pkg::DIR_SINK, 1, 1, 1, 1);     // orthogonal to bidir: no source
        send_fields(0, cis_pkg::DIR_SOURCE, 0, 1, 1, 1);   // orthogonal to bidir: no sink
        send_fields(0, cis_pkg::DIR_SINK, 1, 1, 1, 0);     // new search in the middle
        send_fields(1, cis_pkg::DIR_SOURCE, 0, 1, 1, 1);
        send_fields(1, cis_pkg::DIR_SINK, 1, 3, 1, 1);     // sink-only streams
        send_fields(1, cis_pkg::DIR_SINK, 1, 200, 1, 0);   // sink sum wraps to 1
        send_fields(0, cis_pkg::DIR_SINK, 1, 57, 1, 0);
        send_fields(0, cis_pkg::DIR_SOURCE, 1, 1, 1, 1);
        send_fields(0, cis_pkg::DIR_SINK, 1, 255, 255, 1); // field maxima
        send_fields(0, cis_pkg::DIR_SOURCE, 3, 0, 0, 1);   // device count zero
        drain();

        // Random phases over a spread of settings, extremes included.
        // Strategy data 8'hFF selects code 3 and checks the field masking.
        apply_settings(8'd1, 8'd0, 8'd8, 8'd8);
        run_phase(PHASE_REQUESTS);
        apply_settings(8'd2, 8'd2, 8'd255, 8'd255);
        run_phase(PHASE_REQUESTS);
        apply_settings(8'd0, 8'd1, 8'd0, 8'd5);
        run_phase(PHASE_REQUESTS);
        apply_settings(8'd255, 8'hFF, 8'd1, 8'd0);
        run_phase(PHASE_REQUESTS);
        apply_settings(8'd1, 8'd2, 8'd255, 8'd0);
        run_phase(PHASE_REQUESTS);
        apply_settings(DW'($urandom_range(1, 3)), DW'($urandom_range(0, 255)),
                       DW'($urandom_range(1, 255)), DW'($urandom_range(1, 255)));
        run_phase(PHASE_REQUESTS);

        // Back-to-back traffic on both sides to close.
        quiet_tail = 1'b1;
        apply_settings(8'd1, 8'd1, 8'd4, 8'd4);
        run_phase(PHASE_REQUESTS);

        failures = board.mismatches + board.pending_counts.size();
        $display("Sent %0d entry requests under %0d register settings.",
                 board.entries_seen, settings_used + 1);
        $display("Checked %0d results, %0d configurations fit, %0d mismatches.",
                 board.results_seen, board.configs_fit, board.mismatches);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
